FILE: rtl/core/grid_center_point_downsample_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the grid centre point downsampler
// Concurrent checks on clk_i, removed entirely in synthesis builds.
// ---------------------------------------------------------------------------
`ifndef GRID_CENTER_POINT_DOWNSAMPLE_ASSERT_SVH
`define GRID_CENTER_POINT_DOWNSAMPLE_ASSERT_SVH

`ifndef SYNTHESIS
`define GCPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define GCPD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define GCPD_ASSERT(lbl, prop, msg)
`define GCPD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: rtl/core/gcpd_pkg.sv
// ---------------------------------------------------------------------------
// gcpd_pkg
// Shared constants and types of the grid centre point downsampler.
// ---------------------------------------------------------------------------
package gcpd_pkg;

  localparam int MaxHalfCells = 31;
  localparam int CoordBits    = 16;
  localparam int TagBits      = 16;
  localparam int CsBits       = 14;
  localparam int MrBits       = 15;
  localparam int DistW        = 32;

  localparam int Side  = 2 * MaxHalfCells + 1;
  localparam int Cells = Side * Side;
  localparam int AddrW = $clog2(Cells + 1);
  localparam int QW    = $clog2(Side + 1);
  localparam int NW    = $clog2(MaxHalfCells + 1);
  localparam int StepW = $clog2(QW + 1);
  // Holds the largest shifted divisor and the largest axis numerator, signed.
  localparam int AluW  = CsBits + QW + 3;
  localparam int MulW  = CoordBits;
  localparam int ProdW = 2 * MulW;
  localparam int WordW = 3 * CoordBits;

  localparam logic [CsBits-1:0] CsReset = CsBits'(64);
  localparam logic [MrBits-1:0] MrReset = MrBits'(1984);

  typedef enum logic [0:0] {
    CFG_CELL_SIZE = 1'b0,
    CFG_MAX_RANGE = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic                   sub;
    logic signed [AluW-1:0] a;
    logic signed [AluW-1:0] b;
    logic signed [MulW-1:0] ma;
    logic signed [MulW-1:0] mb;
  } alu_req_t;

  typedef struct packed {
    logic signed [AluW-1:0]  diff;
    logic                    ge;
    logic signed [ProdW-1:0] prod;
  } alu_rsp_t;

  typedef struct packed {
    logic                 occ;
    logic [DistW-1:0]     sqd;
    logic [TagBits-1:0]   tag;
    logic [CoordBits-1:0] y;
    logic [CoordBits-1:0] x;
  } cell_t;

endpackage

FILE: rtl/core/gcpd_alu.sv
// ---------------------------------------------------------------------------
// gcpd_alu
// Shared add/subtract-and-compare unit plus one signed multiplier.
// ---------------------------------------------------------------------------
module gcpd_alu (
  input  gcpd_pkg::alu_req_t req_i,
  output gcpd_pkg::alu_rsp_t rsp_o
);
  import gcpd_pkg::*;

  always_comb begin
    rsp_o.diff = req_i.sub ? (req_i.a - req_i.b) : (req_i.a + req_i.b);
    rsp_o.ge   = ~rsp_o.diff[AluW-1];
    rsp_o.prod = req_i.ma * req_i.mb;
  end

endmodule

FILE: rtl/core/gcpd_ram.sv
// ---------------------------------------------------------------------------
// gcpd_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ---------------------------------------------------------------------------
module gcpd_ram #(
  parameter int Depth = 4,
  parameter int Width = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/grid_center_point_downsample.sv
// ---------------------------------------------------------------------------
// grid_center_point_downsample
// Keeps, for each square grid cell, the point nearest the cell centre.
// ---------------------------------------------------------------------------
// Input words arrive on s_axis; tuser selects add (0) or fetch (1). An add
// word places the point in its cell and yields no output; a fetch word yields
// exactly one output word on m_axis: the next kept point in row-major order
// with tuser (found) high, or, once all cells are passed, a zero word with
// found low, after which the store is cleared.
// An add runs a seven-step shift-subtract division for the grid size and one
// per axis, all on the single shared subtract unit, then squares both offsets
// on the shared multiplier and does a read-modify-write of the cell RAM. A
// point dropped early or a quotient beyond the field ends sooner.
// A fetch reads and checks one cell at a time through the single RAM read
// port, skipping empty cells, until it finds a kept point or the grid's end.
// Only one word is in flight: s_axis_tready is low from acceptance until
// the word is done and any result taken, so a stalled receiver holds the
// block. After reset and each end-of-frame word a clearing pass over all
// 3969 cells runs before s_axis_tready rises. Configuration writes are
// taken on any cycle and must only be issued while idle.
// ---------------------------------------------------------------------------
module grid_center_point_downsample (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [14:0] cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // point_x, point_y, point_tag
  input  logic [0:0]  s_axis_tuser_i,   // action
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // out_x, out_y, out_tag
  output logic [0:0]  m_axis_tuser_o    // found
);
  import gcpd_pkg::*;

  `include "grid_center_point_downsample_assert.svh"

  typedef enum logic [12:0] {
    ST_IDLE  = 13'b0000000000001,
    ST_NINIT = 13'b0000000000010,
    ST_DIV   = 13'b0000000000100,
    ST_MUL   = 13'b0000000001000,
    ST_NUM   = 13'b0000000010000,
    ST_CTR   = 13'b0000000100000,
    ST_SQX   = 13'b0000001000000,
    ST_SQY   = 13'b0000010000000,
    ST_UPD   = 13'b0000100000000,
    ST_FRD   = 13'b0001000000000,
    ST_FCHK  = 13'b0010000000000,
    ST_OUT   = 13'b0100000000000,
    ST_CLEAR = 13'b1000000000000
  } state_e;

  typedef enum logic [1:0] {
    PH_N = 2'd0,
    PH_X = 2'd1,
    PH_Y = 2'd2
  } phase_e;

  typedef struct packed {
    logic signed [AluW-1:0] rem;
    logic signed [AluW-1:0] dsh;
    logic signed [AluW-1:0] csn;
    logic [StepW-1:0]       step;
    logic [QW-1:0]          qv;
    logic [QW-1:0]          side;
    logic [QW-1:0]          jx;
    logic [QW-1:0]          jy;
    logic signed [MulW-1:0] dx;
    logic signed [MulW-1:0] dy;
    logic [DistW-1:0]       dsq;
    logic [DistW-1:0]       dsum;
    logic [AddrW-1:0]       idx;
    logic [CoordBits-1:0]   px;
    logic [CoordBits-1:0]   py;
    logic [TagBits-1:0]     tag;
  } work_t;

  state_e              state_q, state_d;
  phase_e              ph_q, ph_d;
  work_t               w_q, w_d;
  logic [AddrW-1:0]    cur_q, cur_d;
  logic [AddrW-1:0]    clr_q, clr_d;
  logic [CsBits-1:0]   cs_q, cs_d;
  logic [MrBits-1:0]   mr_q, mr_d;
  logic                mvalid_q, mvalid_d;
  logic [WordW-1:0]    mdata_q, mdata_d;
  logic                mfound_q, mfound_d;
  logic                isend_q, isend_d;

  alu_req_t            alu_req;
  alu_rsp_t            alu_rsp;
  logic                ram_we;
  logic [AddrW-1:0]    ram_waddr, ram_raddr;
  cell_t               ram_wdata, ram_rdata;

  logic [CsBits-1:0]   c_eff;
  logic signed [AluW-1:0] dsh_init;
  logic                div_done, div_ovf;
  logic [QW-1:0]       qn;
  logic [CoordBits-1:0] coord_sel;

  gcpd_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  gcpd_ram #(
    .Depth (Cells),
    .Width ($bits(cell_t))
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // A cell size of zero is treated as one.
  assign c_eff     = (cs_q == '0) ? CsBits'(1) : cs_q;
  assign dsh_init  = AluW'({c_eff, {(QW + 1){1'b0}}});
  assign coord_sel = (ph_q == PH_Y) ? w_q.py : w_q.px;

  // The first division step only tests for a quotient beyond the field.
  assign div_ovf  = (state_q == ST_DIV) && (w_q.step == '0) && alu_rsp.ge;
  assign div_done = div_ovf || ((state_q == ST_DIV) && (w_q.step == StepW'(QW)));
  assign qn       = {w_q.qv[QW-2:0], alu_rsp.ge};

  always_comb begin
    alu_req = '0;
    case (state_q)
      ST_NINIT: begin
        alu_req.sub = 1'b1;
        alu_req.a   = AluW'({mr_q, 1'b0});
        alu_req.b   = AluW'(c_eff);
      end
      ST_DIV: begin
        alu_req.sub = 1'b1;
        alu_req.a   = w_q.rem;
        alu_req.b   = w_q.dsh;
      end
      ST_MUL: begin
        alu_req.ma = MulW'(c_eff);
        alu_req.mb = MulW'(w_q.side);
      end
      ST_NUM: begin
        alu_req.sub = 1'b0;
        alu_req.a   = w_q.csn;
        alu_req.b   = AluW'($signed({coord_sel, 1'b0}));
      end
      ST_CTR: begin
        alu_req.sub = 1'b1;
        alu_req.a   = w_q.rem;
        alu_req.b   = AluW'(c_eff);
      end
      ST_SQX: begin
        alu_req.ma = w_q.dx;
        alu_req.mb = w_q.dx;
      end
      ST_SQY: begin
        alu_req.ma = w_q.dy;
        alu_req.mb = w_q.dy;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    ph_d      = ph_q;
    w_d       = w_q;
    cur_d     = cur_q;
    clr_d     = clr_q;
    cs_d      = cs_q;
    mr_d      = mr_q;
    mvalid_d  = mvalid_q;
    mdata_d   = mdata_q;
    mfound_d  = mfound_q;
    isend_d   = isend_q;
    ram_we    = 1'b0;
    ram_waddr = w_q.idx;
    ram_wdata = '0;
    ram_raddr = w_q.idx;

    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_CELL_SIZE: cs_d = cfg_wdata_i[CsBits-1:0];
        CFG_MAX_RANGE: mr_d = cfg_wdata_i[MrBits-1:0];
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          w_d.px  = s_axis_tdata_i[CoordBits-1:0];
          w_d.py  = s_axis_tdata_i[2*CoordBits-1:CoordBits];
          w_d.tag = s_axis_tdata_i[WordW-1:2*CoordBits];
          state_d = s_axis_tuser_i[0] ? ST_FRD : ST_NINIT;
        end
      end
      ST_NINIT: begin
        if (!alu_rsp.ge) begin
          state_d = ST_IDLE;
        end else begin
          w_d.rem  = alu_rsp.diff;
          w_d.dsh  = dsh_init;
          w_d.step = '0;
          w_d.qv   = '0;
          ph_d     = PH_N;
          state_d  = ST_DIV;
        end
      end
      ST_DIV: begin
        if (w_q.step != '0 && alu_rsp.ge) begin
          w_d.rem = alu_rsp.diff;
        end
        if (w_q.step != '0) begin
          w_d.qv = qn;
        end
        w_d.dsh  = w_q.dsh >>> 1;
        w_d.step = w_q.step + StepW'(1);
        if (div_done) begin
          case (ph_q)
            PH_N: begin
              if (div_ovf || qn > QW'(MaxHalfCells)) begin
                w_d.side = QW'(Side);
              end else begin
                w_d.side = {qn[NW-1:0], 1'b1};
              end
              state_d = ST_MUL;
            end
            PH_X: begin
              w_d.jx  = qn;
              state_d = (div_ovf || qn >= w_q.side) ? ST_IDLE : ST_CTR;
            end
            default: begin
              w_d.jy  = qn;
              state_d = (div_ovf || qn >= w_q.side) ? ST_IDLE : ST_CTR;
            end
          endcase
        end
      end
      ST_MUL: begin
        w_d.csn = AluW'(alu_rsp.prod);
        ph_d    = PH_X;
        state_d = ST_NUM;
      end
      ST_NUM: begin
        if (!alu_rsp.ge) begin
          state_d = ST_IDLE;
        end else begin
          w_d.rem  = alu_rsp.diff;
          w_d.dsh  = dsh_init;
          w_d.step = '0;
          w_d.qv   = '0;
          state_d  = ST_DIV;
        end
      end
      ST_CTR: begin
        // The remainder less one cell size is the doubled offset from centre.
        if (ph_q == PH_X) begin
          w_d.dx  = MulW'(alu_rsp.diff);
          ph_d    = PH_Y;
          state_d = ST_NUM;
        end else begin
          w_d.dy  = MulW'(alu_rsp.diff);
          state_d = ST_SQX;
        end
      end
      ST_SQX: begin
        w_d.dsq = DistW'($unsigned(alu_rsp.prod));
        w_d.idx = AddrW'(w_q.jy) * AddrW'(Side) + AddrW'(w_q.jx);
        state_d = ST_SQY;
      end
      ST_SQY: begin
        w_d.dsum  = w_q.dsq + DistW'($unsigned(alu_rsp.prod));
        ram_raddr = w_q.idx;
        state_d   = ST_UPD;
      end
      ST_UPD: begin
        // On a tie the point already held stays.
        if (!ram_rdata.occ || w_q.dsum < ram_rdata.sqd) begin
          ram_we         = 1'b1;
          ram_waddr      = w_q.idx;
          ram_wdata.occ  = 1'b1;
          ram_wdata.sqd  = w_q.dsum;
          ram_wdata.tag  = w_q.tag;
          ram_wdata.y    = w_q.py;
          ram_wdata.x    = w_q.px;
        end
        state_d = ST_IDLE;
      end
      ST_FRD: begin
        ram_raddr = cur_q;
        if (cur_q == AddrW'(Cells)) begin
          mdata_d  = '0;
          mfound_d = 1'b0;
          mvalid_d = 1'b1;
          isend_d  = 1'b1;
          state_d  = ST_OUT;
        end else begin
          state_d = ST_FCHK;
        end
      end
      ST_FCHK: begin
        cur_d = cur_q + AddrW'(1);
        if (ram_rdata.occ) begin
          mdata_d  = {ram_rdata.tag, ram_rdata.y, ram_rdata.x};
          mfound_d = 1'b1;
          mvalid_d = 1'b1;
          isend_d  = 1'b0;
          state_d  = ST_OUT;
        end else begin
          state_d = ST_FRD;
        end
      end
      ST_OUT: begin
        if (m_axis_tready_i) begin
          mvalid_d = 1'b0;
          if (isend_q) begin
            clr_d   = '0;
            cur_d   = '0;
            state_d = ST_CLEAR;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = clr_q + AddrW'(1);
        if (clr_q == AddrW'(Cells - 1)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      ph_q     <= PH_N;
      cur_q    <= '0;
      clr_q    <= '0;
      cs_q     <= CsReset;
      mr_q     <= MrReset;
      mvalid_q <= 1'b0;
      isend_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      ph_q     <= ph_d;
      cur_q    <= cur_d;
      clr_q    <= clr_d;
      cs_q     <= cs_d;
      mr_q     <= mr_d;
      mvalid_q <= mvalid_d;
      isend_q  <= isend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q      <= w_d;
    mdata_q  <= mdata_d;
    mfound_q <= mfound_d;
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = mvalid_q;
  assign m_axis_tdata_o  = mdata_q;
  assign m_axis_tuser_o  = mfound_q;

  `GCPD_ASSERT_ALWAYS(a_one_in_flight, m_axis_tvalid_o |-> !s_axis_tready_o,
                      "input accepted while a result word is pending")
  `GCPD_ASSERT(a_clear_after_end,
               (m_axis_tvalid_o && m_axis_tready_i && !m_axis_tuser_o) |=>
               (state_q == ST_CLEAR), "no clearing pass after end-of-frame word")
  `GCPD_ASSERT(a_write_states, ram_we |-> (state_q == ST_CLEAR || state_q == ST_UPD),
               "cell RAM written outside update or clearing")
  `GCPD_ASSERT(a_cell_in_grid,
               (state_q == ST_SQX) |-> (w_q.jx < w_q.side && w_q.jy < w_q.side),
               "cell index outside the grid")

endmodule
